/* rtl/core/gsi_pkg.sv */
// ----------------------------------------------------------------------------
// gsi_pkg
// Types and constants shared by the Gouraud span interpolator modules.
// ----------------------------------------------------------------------------
package gsi_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned CIN_W   = 10;
  localparam int unsigned COUT_W  = 8;
  localparam int unsigned CNT_W   = 6;   // point index within a span, up to 63
  localparam int unsigned NCOLOR  = 3;
  localparam int unsigned NLANE   = 4;   // depth plus three colors
  localparam int unsigned LANE_DEPTH = 0;

  typedef struct packed {
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        x_start;
    logic [COORD_W-1:0]        x_end;
    logic signed [DEPTH_W-1:0] depth_start;
    logic signed [DEPTH_W-1:0] depth_end;
    logic [CIN_W-1:0]          start_red;
    logic [CIN_W-1:0]          start_green;
    logic [CIN_W-1:0]          start_blue;
    logic [CIN_W-1:0]          end_red;
    logic [CIN_W-1:0]          end_green;
    logic [CIN_W-1:0]          end_blue;
  } gsi_span_t;

  typedef struct packed {
    logic [COORD_W-1:0]        point_x;
    logic [COORD_W-1:0]        point_row;
    logic signed [DEPTH_W-1:0] point_depth;
    logic [COUT_W-1:0]         out_red;
    logic [COUT_W-1:0]         out_green;
    logic [COUT_W-1:0]         out_blue;
    logic                      last_point;
    logic                      truncated;
  } gsi_point_t;

  // Classified span as it waits between front and back.
  typedef struct packed {
    logic [COORD_W-1:0]              row;
    logic [COORD_W-1:0]              x_start;
    logic [COORD_W-1:0]              len;
    logic [CNT_W-1:0]                last_idx;
    logic                            trunc;
    logic signed [DEPTH_W-1:0]       depth_start;
    logic signed [DEPTH_W-1:0]       depth_end;
    logic [NCOLOR-1:0][CIN_W-1:0]    color_start;
    logic [NCOLOR-1:0][CIN_W-1:0]    color_end;
  } gsi_desc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } gsi_state_t;

endpackage

/* rtl/core/gsi_if.sv */
// ----------------------------------------------------------------------------
// gsi_if
// Valid/ready channels for span beats and point beats.
// ----------------------------------------------------------------------------
interface gsi_span_if;
  import gsi_pkg::*;
  logic      valid;
  logic      ready;
  gsi_span_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gsi_point_if;
  import gsi_pkg::*;
  logic       valid;
  logic       ready;
  gsi_point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/gsi_front.sv */
// ----------------------------------------------------------------------------
// gsi_front
// Accepts span beats, masks coordinates, drops reversed spans and works out
// the point count and the truncation flag.
// ----------------------------------------------------------------------------
module gsi_front #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 12
) (
  gsi_span_if.sink          in_span,
  output logic              push_valid,
  output gsi_pkg::gsi_desc_t push_desc,
  input  logic              push_ready
);
  import gsi_pkg::*;

  localparam logic [COORD_W-1:0] CMASK =
    (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} : COORD_W'((1 << COORD_BITS) - 1);

  logic [COORD_W-1:0] xs;
  logic [COORD_W-1:0] xe;
  logic               reversed;

  assign xs       = in_span.data.x_start & CMASK;
  assign xe       = in_span.data.x_end & CMASK;
  assign reversed = xe < xs;

  // A reversed span is taken and dropped without reaching the queue.
  assign in_span.ready = push_ready;
  assign push_valid    = in_span.valid && !reversed;

  always_comb begin
    push_desc             = '0;
    push_desc.row         = in_span.data.row & CMASK;
    push_desc.x_start     = xs;
    push_desc.len         = xe - xs;
    push_desc.trunc       = {1'b0, push_desc.len} >= (COORD_W + 1)'(MAX_POINTS);
    push_desc.last_idx    = push_desc.trunc ? CNT_W'(MAX_POINTS - 1)
                                            : push_desc.len[CNT_W-1:0];
    push_desc.depth_start = in_span.data.depth_start;
    push_desc.depth_end   = in_span.data.depth_end;
    push_desc.color_start = {in_span.data.start_blue, in_span.data.start_green,
                             in_span.data.start_red};
    push_desc.color_end   = {in_span.data.end_blue, in_span.data.end_green,
                             in_span.data.end_red};
  end

endmodule

/* rtl/core/gsi_queue.sv */
// ----------------------------------------------------------------------------
// gsi_queue
// Two-entry queue of classified spans between front and back.
// ----------------------------------------------------------------------------
module gsi_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  gsi_pkg::gsi_desc_t push_desc,
  output logic               push_ready,
  output logic               pop_valid,
  output gsi_pkg::gsi_desc_t pop_desc,
  input  logic               pop_ready
);
  import gsi_pkg::*;

  gsi_desc_t  mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_desc   = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = do_push ? !wptr_r : wptr_r;
    rptr_nxt = do_pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_desc;
    end
  end

endmodule

/* rtl/core/gsi_back.sv */
// ----------------------------------------------------------------------------
// gsi_back
// Divides out the four slopes two quotient bits a cycle, then steps the
// depth and color accumulators once per emitted point.
// ----------------------------------------------------------------------------
module gsi_back #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  gsi_pkg::gsi_desc_t pop_desc,
  output logic               pop_ready,
  gsi_point_if.source        out_point
);
  import gsi_pkg::*;

  localparam int unsigned DN     = ((FRAC_BITS + 18) / 2) * 2;
  localparam int unsigned ITER   = DN / 2;
  localparam int unsigned IT_W   = $clog2(ITER + 1);
  localparam int unsigned DACC_W = FRAC_BITS + 24;
  localparam int unsigned CACC_W = FRAC_BITS + 13;
  localparam logic signed [CACC_W-1:0] CMAX = CACC_W'(255) <<< FRAC_BITS;
  localparam logic [COORD_W-1:0] CMASK =
    (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} : COORD_W'((1 << COORD_BITS) - 1);

  gsi_state_t state_r, state_nxt;

  logic [IT_W-1:0]                 iter_r;
  logic [COORD_W-1:0]              len_r;
  logic [COORD_W-1:0]              x_r;
  logic [COORD_W-1:0]              row_r;
  logic [CNT_W-1:0]                left_r;
  logic                            trunc_r;
  logic signed [DACC_W-1:0]        dacc_r;
  logic signed [CACC_W-1:0]        cacc_r [NCOLOR];
  logic [DN-1:0]                   num_r  [NLANE];
  logic [COORD_W-1:0]              rem_r  [NLANE];
  logic                            neg_r  [NLANE];
  logic                            ov_r;
  gsi_point_t                      out_r;

  logic                            load;
  logic                            div_en;
  logic                            emit;
  logic                            slot_free;

  logic [DN-1:0]                   num_nxt [NLANE];
  logic [COORD_W-1:0]              rem_nxt [NLANE];
  logic [DN-1:0]                   mag_ld  [NLANE];
  logic                            neg_ld  [NLANE];
  logic signed [DACC_W-1:0]        dstep;
  logic signed [CACC_W-1:0]        cstep  [NCOLOR];
  logic signed [CACC_W-1:0]        cclamp [NCOLOR];

  assign slot_free = !ov_r || out_point.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (pop_valid) state_nxt = ST_DIV;
      ST_DIV:  if (iter_r == IT_W'(ITER - 1)) state_nxt = ST_EMIT;
      ST_EMIT: if (slot_free && left_r == '0) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    load   = 1'b0;
    div_en = 1'b0;
    emit   = 1'b0;
    case (state_r)
      ST_IDLE: load   = pop_valid;
      ST_DIV:  div_en = 1'b1;
      ST_EMIT: emit   = slot_free;
      default: ;
    endcase
  end

  assign pop_ready = state_r == ST_IDLE;

  // Sign and magnitude of each end difference, scaled to fixed point.
  always_comb begin
    logic signed [DEPTH_W:0] dd;
    logic signed [CIN_W:0]   cd;
    dd = {pop_desc.depth_end[DEPTH_W-1], pop_desc.depth_end}
       - {pop_desc.depth_start[DEPTH_W-1], pop_desc.depth_start};
    neg_ld[LANE_DEPTH] = dd[DEPTH_W];
    mag_ld[LANE_DEPTH] = DN'(dd[DEPTH_W] ? -dd : dd) << FRAC_BITS;
    for (int c = 0; c < NCOLOR; c++) begin
      cd = {1'b0, pop_desc.color_end[c]} - {1'b0, pop_desc.color_start[c]};
      neg_ld[c+1] = cd[CIN_W];
      mag_ld[c+1] = DN'(cd[CIN_W] ? -cd : cd) << FRAC_BITS;
    end
  end

  // Two restoring division steps per lane and cycle.
  always_comb begin
    logic [COORD_W:0] r;
    logic [DN-1:0]    n;
    logic [COORD_W-1:0] rm;
    for (int l = 0; l < NLANE; l++) begin
      n  = num_r[l];
      rm = rem_r[l];
      for (int s = 0; s < 2; s++) begin
        r = {rm, n[DN-1]};
        if (r >= {1'b0, len_r}) begin
          r = r - {1'b0, len_r};
          n = {n[DN-2:0], 1'b1};
        end else begin
          n = {n[DN-2:0], 1'b0};
        end
        rm = r[COORD_W-1:0];
      end
      num_nxt[l] = n;
      rem_nxt[l] = rm;
    end
  end

  // Signed slopes from the finished quotients, and the color clamp.
  always_comb begin
    logic signed [DACC_W-1:0] dq;
    logic signed [CACC_W-1:0] cq;
    dq    = signed'({{(DACC_W - DN){1'b0}}, num_r[LANE_DEPTH]});
    dstep = neg_r[LANE_DEPTH] ? -dq : dq;
    for (int c = 0; c < NCOLOR; c++) begin
      cq       = signed'(num_r[c+1][CACC_W-1:0]);
      cstep[c] = neg_r[c+1] ? -cq : cq;
      if (cacc_r[c] < 0) begin
        cclamp[c] = '0;
      end else if (cacc_r[c] > CMAX) begin
        cclamp[c] = CMAX;
      end else begin
        cclamp[c] = cacc_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_point.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      iter_r  <= '0;
      len_r   <= pop_desc.len;
      x_r     <= pop_desc.x_start;
      row_r   <= pop_desc.row;
      left_r  <= pop_desc.last_idx;
      trunc_r <= pop_desc.trunc;
      dacc_r  <= DACC_W'(pop_desc.depth_start) <<< FRAC_BITS;
      for (int c = 0; c < NCOLOR; c++) begin
        cacc_r[c] <= CACC_W'({1'b0, pop_desc.color_start[c]}) <<< FRAC_BITS;
      end
      for (int l = 0; l < NLANE; l++) begin
        num_r[l] <= mag_ld[l];
        rem_r[l] <= '0;
        neg_r[l] <= neg_ld[l];
      end
    end
    if (div_en) begin
      iter_r <= iter_r + 1'b1;
      for (int l = 0; l < NLANE; l++) begin
        num_r[l] <= num_nxt[l];
        rem_r[l] <= rem_nxt[l];
      end
    end
    if (emit) begin
      out_r.point_x     <= x_r;
      out_r.point_row   <= row_r;
      out_r.point_depth <= dacc_r[FRAC_BITS +: DEPTH_W];
      out_r.out_red     <= cclamp[0][FRAC_BITS +: COUT_W];
      out_r.out_green   <= cclamp[1][FRAC_BITS +: COUT_W];
      out_r.out_blue    <= cclamp[2][FRAC_BITS +: COUT_W];
      out_r.last_point  <= left_r == '0;
      out_r.truncated   <= trunc_r;
      dacc_r <= dacc_r + dstep;
      for (int c = 0; c < NCOLOR; c++) begin
        cacc_r[c] <= cclamp[c] + cstep[c];
      end
      x_r    <= (x_r + 1'b1) & CMASK;
      left_r <= left_r - 1'b1;
    end
  end

  assign out_point.valid = ov_r;
  assign out_point.data  = out_r;

endmodule

/* rtl/core/gouraud_span_interpolator.sv */
// ----------------------------------------------------------------------------
// gouraud_span_interpolator
// Scanline span interpolator: depth and RGB stepped in fixed point.
// ----------------------------------------------------------------------------
// Usage: in_span takes one span beat (row, start/end x, depth and color at
// both ends) when valid and ready are high. out_point gives one point beat
// per x step from start to end inclusive, with last_point set on the final
// point of the span. Spans with an end before the start produce no beats;
// spans of more than MAX_POINTS points stop after MAX_POINTS beats, all
// flagged truncated.
// Flow: a two-entry span queue decouples intake from the back end. The
// back end works on one span at a time: it loads the span, runs the four
// slope divisions side by side at two quotient bits a cycle, and then
// emits the points of the span in order of x.
// Reset clears the queue, the sequencer and the output valid flag.
// A stalled receiver holds the current point; the queue keeps taking spans
// until both entries are full.
// ----------------------------------------------------------------------------
module gouraud_span_interpolator #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  gsi_span_if.sink     in_span,
  gsi_point_if.source  out_point
);
  import gsi_pkg::*;

  logic      push_valid;
  logic      push_ready;
  gsi_desc_t push_desc;
  logic      pop_valid;
  logic      pop_ready;
  gsi_desc_t pop_desc;

  gsi_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_span    (in_span),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .push_ready (push_ready)
  );

  gsi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_desc   (pop_desc),
    .pop_ready  (pop_ready)
  );

  gsi_back #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_desc  (pop_desc),
    .pop_ready (pop_ready),
    .out_point (out_point)
  );

endmodule

/* tb/gouraud_span_interpolator_tb.sv */
// ----------------------------------------------------------------------------
// gouraud_span_interpolator_tb
// Drives spans into the interpolator, predicts every point in fixed point and
// checks each point beat field by field, with random gaps on both channels.
// ----------------------------------------------------------------------------
module gouraud_span_interpolator_tb;
  import gsi_pkg::*;

  localparam int MAX_PTS = 64;
  localparam int FRACB = 16;
  localparam longint COLOR_TOP = longint'(255) <<< FRACB;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gsi_span_if  span_ch ();
  gsi_point_if point_ch ();

  gouraud_span_interpolator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_span   (span_ch.sink),
    .out_point (point_ch.source)
  );

  always #1 clk = ~clk;

  gsi_span_t  span_queue[$];
  gsi_point_t point_queue[$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         send_gap = 0;
  int         recv_gap = 0;
  bit         stim_done = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Division truncates toward zero, as in the slope definition.
  function automatic longint span_slope(longint a, longint b, longint len);
    longint num;
    longint q;
    if (len <= 0) return 0;
    num = (b - a) <<< FRACB;
    q = (num < 0 ? -num : num) / len;
    return num < 0 ? -q : q;
  endfunction

  task automatic predict_points(input gsi_span_t s);
    longint     len;
    int         n;
    bit         cut;
    longint     dacc;
    longint     dstep;
    longint     cacc[3];
    longint     cstep[3];
    longint     cs[3];
    longint     ce[3];
    logic [11:0] x;
    gsi_point_t p;
    if (s.x_end < s.x_start) return;
    cs[0] = longint'(s.start_red);
    cs[1] = longint'(s.start_green);
    cs[2] = longint'(s.start_blue);
    ce[0] = longint'(s.end_red);
    ce[1] = longint'(s.end_green);
    ce[2] = longint'(s.end_blue);
    len = longint'(s.x_end) - longint'(s.x_start);
    cut = (len + 1) > MAX_PTS;
    n = cut ? MAX_PTS : int'(len + 1);
    dacc = longint'(s.depth_start) <<< FRACB;
    dstep = span_slope(longint'(s.depth_start), longint'(s.depth_end), len);
    for (int c = 0; c < 3; c++) begin
      cacc[c] = cs[c] <<< FRACB;
      cstep[c] = span_slope(cs[c], ce[c], len);
    end
    x = s.x_start;
    for (int k = 0; k < n; k++) begin
      for (int c = 0; c < 3; c++) begin
        if (cacc[c] > COLOR_TOP) cacc[c] = COLOR_TOP;
        if (cacc[c] < 0) cacc[c] = 0;
      end
      p.point_x = x;
      p.point_row = s.row;
      p.point_depth = 16'(dacc >>> FRACB);
      p.out_red = 8'(cacc[0] >>> FRACB);
      p.out_green = 8'(cacc[1] >>> FRACB);
      p.out_blue = 8'(cacc[2] >>> FRACB);
      p.last_point = (k == n - 1);
      p.truncated = cut;
      point_queue.push_back(p);
      dacc += dstep;
      for (int c = 0; c < 3; c++) cacc[c] += cstep[c];
      x = x + 12'd1;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic gsi_span_t random_span(input bit full_range);
    gsi_span_t s;
    s = '0;
    s.row = 12'($urandom);
    s.x_start = 12'($urandom);
    case ($urandom_range(0, 9))
      0: s.x_end = s.x_start - 12'($urandom_range(1, 20));
      1: s.x_end = s.x_start;
      2: s.x_end = s.x_start + 12'($urandom_range(64, 300));
      default: s.x_end = s.x_start + 12'($urandom_range(1, 40));
    endcase
    if (full_range) s.x_end = 12'($urandom);
    s.depth_start = 16'($urandom);
    s.depth_end = 16'($urandom);
    s.start_red = 10'($urandom);
    s.start_green = 10'($urandom);
    s.start_blue = 10'($urandom);
    s.end_red = 10'($urandom);
    s.end_green = 10'($urandom);
    s.end_blue = 10'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      s.start_red = 10'($urandom_range(0, 255));
      s.end_green = 10'($urandom_range(0, 255));
    end
    return s;
  endfunction

  function automatic gsi_span_t make_span(int xs, int xe, int ds, int de, int c0, int c1);
    gsi_span_t s;
    s.row = 12'($urandom);
    s.x_start = 12'(xs);
    s.x_end = 12'(xe);
    s.depth_start = 16'(ds);
    s.depth_end = 16'(de);
    s.start_red = 10'(c0); s.start_green = 10'(c1); s.start_blue = 10'(c0);
    s.end_red = 10'(c1);   s.end_green = 10'(c0);   s.end_blue = 10'(c1);
    return s;
  endfunction

  initial begin
    gsi_span_t s;
    span_queue.push_back(make_span(0, 0, 0, 0, 0, 0));
    span_queue.push_back(make_span(4095, 4095, 32767, -32768, 1023, 1023));
    span_queue.push_back(make_span(10, 5, 100, 200, 10, 20));
    span_queue.push_back(make_span(4095, 0, 0, 0, 0, 0));
    span_queue.push_back(make_span(0, 4095, -32768, 32767, 0, 1023));
    span_queue.push_back(make_span(0, 63, 0, 1000, 0, 1023));
    span_queue.push_back(make_span(0, 64, -5, 5, 1023, 0));
    span_queue.push_back(make_span(4090, 4095, 32767, -32768, 300, 0));
    span_queue.push_back(make_span(100, 107, -1, -2, 255, 256));
    span_queue.push_back(make_span(7, 9, 3, -3, 1, 2));
    span_queue.push_back(make_span(4000, 4050, 32767, 32767, 512, 1023));
    s = make_span(1, 2, 0, 0, 0, 0);
    s.row = 12'hFFF;
    span_queue.push_back(s);
    s.row = 12'h000;
    span_queue.push_back(s);
    for (int i = 0; i < 137; i++) span_queue.push_back(random_span(i % 25 == 0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_ch.valid <= 1'b0;
      span_ch.data <= '0;
      send_gap <= 0;
    end else if (span_ch.valid && !span_ch.ready) begin
      // Hold the beat until it is taken.
    end else if (send_gap > 0) begin
      span_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (span_queue.size() > 0) begin
      span_ch.valid <= 1'b1;
      span_ch.data <= span_queue.pop_front();
      send_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end else begin
      span_ch.valid <= 1'b0;
      stim_done <= 1'b1;
    end
  end

  // Predictions are made when the input beat is accepted.
  always @(posedge clk) begin
    if (rst_n && span_ch.valid && span_ch.ready) predict_points(span_ch.data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else if (recv_gap > 0) begin
      point_ch.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      point_ch.ready <= 1'b1;
      recv_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    gsi_point_t got;
    gsi_point_t want;
    if (rst_n && point_ch.valid && point_ch.ready) begin
      got = point_ch.data;
      if (point_queue.size() == 0) begin
        report_mismatch("unexpected point at x", got.point_x, -1);
      end else begin
        want = point_queue.pop_front();
        if (got.point_x !== want.point_x)
          report_mismatch("point_x", got.point_x, want.point_x);
        if (got.point_row !== want.point_row)
          report_mismatch("point_row", got.point_row, want.point_row);
        if (got.point_depth !== want.point_depth)
          report_mismatch("point_depth", got.point_depth, want.point_depth);
        if (got.out_red !== want.out_red)
          report_mismatch("out_red", got.out_red, want.out_red);
        if (got.out_green !== want.out_green)
          report_mismatch("out_green", got.out_green, want.out_green);
        if (got.out_blue !== want.out_blue)
          report_mismatch("out_blue", got.out_blue, want.out_blue);
        if (got.last_point !== want.last_point)
          report_mismatch("last_point", got.last_point, want.last_point);
        if (got.truncated !== want.truncated)
          report_mismatch("truncated", got.truncated, want.truncated);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout at cycle %0d", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && point_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && point_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
